/* src/routing_table_with_convergence_timer_core_assert.svh */
// Assertion macros used by the routing table datapath.
`ifndef ROUTING_TABLE_WITH_CONVERGENCE_TIMER_CORE_ASSERT_SVH
`define ROUTING_TABLE_WITH_CONVERGENCE_TIMER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("routing table assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RTCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("routing table assertion failed");

`endif

/* src/rtct_pkg.sv */
// Types and constants shared by the routing table modules.
package rtct_pkg;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_TICK   = 2'd2,
        OP_START  = 2'd3
    } op_t;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_REPLACED = 3'd2;
    localparam logic [2:0] ST_KEPT     = 3'd3;
    localparam logic [2:0] ST_DROPPED  = 3'd4;

    localparam logic [15:0] IDLE_LIMIT_RESET = 16'd300;
    localparam logic [15:0] IDLE_TICKS_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] hop;
        logic        port_present;
        logic [7:0]  port;
        logic [15:0] metric;
        logic        proto;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic resolve;
    } dp_cmd_t;

    typedef struct packed {
        logic table_op;
        logic hit;
        logic miss;
    } dp_status_t;

endpackage

/* src/rtct_ram.sv */
// Generic simple dual-port RAM with registered read.
module rtct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/rtct_datapath.sv */
// Datapath: table memory, scan counter, convergence timer and result registers.
module rtct_datapath import rtct_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [1:0]  op,
    input  logic [31:0] dest_addr,
    input  logic [31:0] subnet_mask,
    input  logic [31:0] next_hop,
    input  logic [7:0]  out_port_in,
    input  logic        port_present_in,
    input  logic [15:0] metric,
    input  logic        proto_ospf,
    input  logic        in_routing_phase,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        result_valid,
    output logic        found,
    output logic [7:0]  out_port,
    output logic        port_present,
    output logic [2:0]  update_status,
    output logic        routing_done
);

    `include "routing_table_with_convergence_timer_core_assert.svh"

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    // held item
    op_t        op_reg, op_next;
    entry_t     item_reg, item_next;
    logic       phase_reg, phase_next;

    // scan control
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;

    // timer state
    logic        changed_reg, changed_next;
    logic [15:0] idle_reg, idle_next;
    logic        started_reg, started_next;
    logic        done_flag_reg, done_flag_next;
    logic [15:0] limit_reg, limit_next;

    // results
    logic        res_valid_reg, res_valid_next;
    logic        found_reg, found_next;
    logic [7:0]  out_port_reg, out_port_next;
    logic        present_reg, present_next;
    logic [2:0]  status_reg, status_next;
    logic        rdone_reg, rdone_next;

    // memory side
    logic [$bits(entry_t)-1:0] rd_data;
    entry_t                    rd_entry;
    logic                      ram_wr_en;
    logic [IDX_W-1:0]          ram_wr_addr;
    logic                      ram_rd_en;

    logic scan_more, hit, miss, full, replace, tick_fire;

    assign rd_entry  = entry_t'(rd_data);
    assign scan_more = scan_idx_reg < count_reg;
    assign hit       = chk_valid_reg && (rd_entry.dest == item_reg.dest);
    assign miss      = !hit && (scan_idx_reg == count_reg);
    assign full      = count_reg == DEPTH_C;
    assign replace   = hit && (rd_entry.metric > item_reg.metric);
    assign tick_fire = phase_reg && started_reg && !done_flag_reg && !changed_reg
                       && (idle_reg >= limit_reg);

    assign status.table_op = (op_reg == OP_UPDATE) || (op_reg == OP_LOOKUP);
    assign status.hit      = hit;
    assign status.miss     = miss;

    assign ram_rd_en   = cmd.scan && scan_more;
    assign ram_wr_en   = cmd.resolve && (op_reg == OP_UPDATE) && ((miss && !full) || replace);
    assign ram_wr_addr = hit ? chk_idx_reg : count_reg[IDX_W-1:0];

    rtct_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (item_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = chk_valid_reg;
        changed_next   = changed_reg;
        idle_next      = idle_reg;
        started_next   = started_reg;
        done_flag_next = done_flag_reg;
        limit_next     = limit_reg;
        res_valid_next = cmd.resolve;

        if (cfg_wr_en)
        begin
            limit_next = cfg_wr_data;
        end

        if (cmd.load)
        begin
            scan_idx_next  = '0;
            chk_valid_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            chk_valid_next = scan_more;
            if (scan_more)
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
        end

        if (cmd.resolve)
        begin
            unique case (op_reg)
                OP_UPDATE:
                begin
                    changed_next = 1'b1;
                    idle_next    = '0;
                    if (miss && !full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_LOOKUP:
                begin
                    count_next = count_reg;
                end
                OP_TICK:
                begin
                    if (!phase_reg)
                    begin
                        started_next   = 1'b0;
                        done_flag_next = 1'b0;
                    end
                    else if (started_reg && !done_flag_reg)
                    begin
                        if (tick_fire)
                        begin
                            done_flag_next = 1'b1;
                        end
                        changed_next = 1'b0;
                        if (idle_reg != IDLE_TICKS_MAX)
                        begin
                            idle_next = idle_reg + 1'b1;
                        end
                    end
                end
                OP_START:
                begin
                    started_next = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        op_next       = op_reg;
        item_next     = item_reg;
        phase_next    = phase_reg;
        chk_idx_next  = chk_idx_reg;
        found_next    = found_reg;
        out_port_next = out_port_reg;
        present_next  = present_reg;
        status_next   = status_reg;
        rdone_next    = rdone_reg;

        if (cmd.load)
        begin
            op_next                = op_t'(op);
            item_next.dest         = dest_addr;
            item_next.mask         = subnet_mask;
            item_next.hop          = next_hop;
            item_next.port_present = port_present_in;
            item_next.port         = out_port_in;
            item_next.metric       = metric;
            item_next.proto        = proto_ospf;
            phase_next             = in_routing_phase;
        end

        if (ram_rd_en)
        begin
            chk_idx_next = scan_idx_reg[IDX_W-1:0];
        end

        if (cmd.resolve)
        begin
            found_next    = 1'b0;
            out_port_next = '0;
            present_next  = 1'b0;
            status_next   = ST_NONE;
            rdone_next    = 1'b0;
            unique case (op_reg)
                OP_UPDATE:
                begin
                    if (miss)
                    begin
                        status_next = full ? ST_DROPPED : ST_INSERTED;
                    end
                    else
                    begin
                        status_next = replace ? ST_REPLACED : ST_KEPT;
                    end
                end
                OP_LOOKUP:
                begin
                    if (hit)
                    begin
                        found_next = 1'b1;
                        if (rd_entry.port_present)
                        begin
                            out_port_next = rd_entry.port;
                            present_next  = 1'b1;
                        end
                    end
                end
                OP_TICK:
                begin
                    rdone_next = tick_fire;
                end
                OP_START:
                begin
                    rdone_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            changed_reg   <= 1'b0;
            idle_reg      <= '0;
            started_reg   <= 1'b0;
            done_flag_reg <= 1'b0;
            limit_reg     <= IDLE_LIMIT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
            changed_reg   <= changed_next;
            idle_reg      <= idle_next;
            started_reg   <= started_next;
            done_flag_reg <= done_flag_next;
            limit_reg     <= limit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        item_reg     <= item_next;
        phase_reg    <= phase_next;
        chk_idx_reg  <= chk_idx_next;
        found_reg    <= found_next;
        out_port_reg <= out_port_next;
        present_reg  <= present_next;
        status_reg   <= status_next;
        rdone_reg    <= rdone_next;
    end

    assign result_valid  = res_valid_reg;
    assign found         = found_reg;
    assign out_port      = out_port_reg;
    assign port_present  = present_reg;
    assign update_status = status_reg;
    assign routing_done  = rdone_reg;

    `RTCT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= DEPTH_C)
    `RTCT_ASSERT_NEXT(a_insert_grows, ram_wr_en && !hit, count_reg == $past(count_reg) + 1'b1)
    `RTCT_ASSERT_NOW(a_done_latched, res_valid_reg && rdone_reg, done_flag_reg)

endmodule

/* src/rtct_ctrl.sv */
// Controller: sequences accept, table scan, resolve and result strobe.
module rtct_ctrl import rtct_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE, S_RESP:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RUN:
            begin
                if (!status.table_op || status.hit || status.miss)
                begin
                    cmd.resolve = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg == S_RUN;

endmodule

/* src/routing_table_with_convergence_timer_core.sv */
// Tick and start words skip the table; table words read an entry per cycle until hit or miss.
// A new word is taken in the strobe cycle of the last result, not while the table is walked.
// The receiver cannot stall: result_valid pulses high for a single cycle; data holds after it.
// Reset (async, active low) empties the table, clears the timer flags, loads idle limit 300.
// No clearing pass: entries past the fill count are never read.
module routing_table_with_convergence_timer_core import rtct_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // command side
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] dest_addr,
    input  logic [31:0] subnet_mask,
    input  logic [31:0] next_hop,
    input  logic [7:0]  out_port_in,
    input  logic        port_present_in,
    input  logic [15:0] metric,
    input  logic        proto_ospf,
    input  logic        in_routing_phase,
    // idle tick limit register
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // result side
    output logic        result_valid,
    output logic        found,
    output logic [7:0]  out_port,
    output logic        port_present,
    output logic [2:0]  update_status,
    output logic        routing_done
);

    // The controller and datapath talk only through these two groups.
    dp_cmd_t    cmd;
    dp_status_t status;

    // Hold the word, walk the table one entry a cycle, then resolve and strobe.
    rtct_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Table memory, first-match scan, metric compare and convergence timer.
    rtct_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .op               (op),
        .dest_addr        (dest_addr),
        .subnet_mask      (subnet_mask),
        .next_hop         (next_hop),
        .out_port_in      (out_port_in),
        .port_present_in  (port_present_in),
        .metric           (metric),
        .proto_ospf       (proto_ospf),
        .in_routing_phase (in_routing_phase),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .result_valid     (result_valid),
        .found            (found),
        .out_port         (out_port),
        .port_present     (port_present),
        .update_status    (update_status),
        .routing_done     (routing_done)
    );

endmodule

/* verif/tb_routing_table_with_convergence_timer_core.sv */
// Self-checking testbench for the routing table core: directed words, random traffic, idle timer.
module tb_routing_table_with_convergence_timer_core import rtct_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUTE_DEPTH = 64;
    localparam int POOL_SIZE   = 40;
    localparam int BLOCK_WORDS = 238;

    // One command word as driven onto the input ports.
    typedef struct {
        op_t         op;
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] hop;
        logic [7:0]  port;
        logic        present;
        logic [15:0] metric;
        logic        proto;
        logic        phase;
    } cmd_word_t;

    // One result word as seen on the output ports.
    typedef struct packed {
        logic       found;
        logic [7:0] port;
        logic       present;
        logic [2:0] status;
        logic       done;
    } reply_t;

    // Scoreboard: mirrors the route table and the convergence timer, and holds
    // the replies still owed by the block, oldest first.
    class route_scoreboard;
        entry_t      routes [ROUTE_DEPTH];
        int          route_count;
        bit          changed_mark;
        bit          started;
        bit          converged;
        logic [15:0] idle_count;
        logic [15:0] idle_limit;
        reply_t      pending_replies [$];
        int          errors;

        function new();
            route_count  = 0;
            changed_mark = 1'b0;
            started      = 1'b0;
            converged    = 1'b0;
            idle_count   = '0;
            idle_limit   = IDLE_LIMIT_RESET;
            errors       = 0;
        endfunction

        function void set_limit(logic [15:0] value);
            idle_limit = value;
        endfunction

        function int find_route(logic [31:0] key);
            for (int i = 0; i < route_count; i++)
            begin
                if (routes[i].dest == key)
                    return i;
            end
            return -1;
        endfunction

        function entry_t make_entry(cmd_word_t w);
            entry_t e;
            e.dest         = w.dest;
            e.mask         = w.mask;
            e.hop          = w.hop;
            e.port_present = w.present;
            e.port         = w.port;
            e.metric       = w.metric;
            e.proto        = w.proto;
            return e;
        endfunction

        // Work out the reply for an accepted word and advance the mirrored state.
        function void note_word(cmd_word_t w);
            reply_t r;
            int     idx;
            r = '0;
            case (w.op)
                OP_UPDATE:
                begin
                    changed_mark = 1'b1;
                    idle_count   = '0;
                    idx          = find_route(w.dest);
                    if (idx < 0)
                    begin
                        if (route_count < ROUTE_DEPTH)
                        begin
                            routes[route_count] = make_entry(w);
                            route_count++;
                            r.status = ST_INSERTED;
                        end
                        else
                            r.status = ST_DROPPED;
                    end
                    else if (routes[idx].metric > w.metric)
                    begin
                        routes[idx] = make_entry(w);
                        r.status    = ST_REPLACED;
                    end
                    else
                        r.status = ST_KEPT;
                end
                OP_LOOKUP:
                begin
                    idx = find_route(w.dest);
                    if (idx >= 0)
                    begin
                        r.found = 1'b1;
                        if (routes[idx].port_present)
                        begin
                            r.port    = routes[idx].port;
                            r.present = 1'b1;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (!w.phase)
                    begin
                        started   = 1'b0;
                        converged = 1'b0;
                    end
                    else if (started && !converged)
                    begin
                        if (!changed_mark && idle_count >= idle_limit)
                        begin
                            converged = 1'b1;
                            r.done    = 1'b1;
                        end
                        changed_mark = 1'b0;
                        if (idle_count != IDLE_TICKS_MAX)
                            idle_count++;
                    end
                end
                default:
                    started = 1'b1;
            endcase
            pending_replies.push_back(r);
        endfunction

        function void check_result(reply_t got);
            reply_t exp;
            if (pending_replies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result word with nothing outstanding: %p", $realtime, got);
                return;
            end
            exp = pending_replies.pop_front();
            if (got.found !== exp.found || got.port !== exp.port ||
                got.present !== exp.present || got.status !== exp.status ||
                got.done !== exp.done)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch exp found=%0b port=%0d present=%0b status=%0d done=%0b",
                             $realtime, exp.found, exp.port, exp.present, exp.status, exp.done,
                             " got found=%0b port=%0d present=%0b status=%0d done=%0b",
                             got.found, got.port, got.present, got.status, got.done);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n            = 1'b0;
    logic        start            = 1'b0;
    logic        busy;
    logic [1:0]  op               = OP_TICK;
    logic [31:0] dest_addr        = '0;
    logic [31:0] subnet_mask      = '0;
    logic [31:0] next_hop         = '0;
    logic [7:0]  out_port_in      = '0;
    logic        port_present_in  = 1'b0;
    logic [15:0] metric           = '0;
    logic        proto_ospf       = 1'b0;
    logic        in_routing_phase = 1'b0;
    logic        cfg_wr_en        = 1'b0;
    logic [15:0] cfg_wr_data      = '0;
    logic        result_valid;
    logic        found;
    logic [7:0]  out_port;
    logic        port_present;
    logic [2:0]  update_status;
    logic        routing_done;

    route_scoreboard sb = new();

    // Destinations that recur, so that updates and lookups hit existing routes.
    logic [31:0] addr_pool [POOL_SIZE];

    routing_table_with_convergence_timer_core #(
        .TABLE_DEPTH(ROUTE_DEPTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .dest_addr        (dest_addr),
        .subnet_mask      (subnet_mask),
        .next_hop         (next_hop),
        .out_port_in      (out_port_in),
        .port_present_in  (port_present_in),
        .metric           (metric),
        .proto_ospf       (proto_ospf),
        .in_routing_phase (in_routing_phase),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .result_valid     (result_valid),
        .found            (found),
        .out_port         (out_port),
        .port_present     (port_present),
        .update_status    (update_status),
        .routing_done     (routing_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sample the result ports at the edge that ends the strobe cycle; the
    // values read here are the ones held before the edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result({found, out_port, port_present, update_status, routing_done});
    end

    // Hold the word on the ports with start high until the block takes it.
    // Start is left high on return: the caller either presents the next word
    // in the same step or drops start through idle_gap or drain.
    task automatic send_word(cmd_word_t w);
        start            <= 1'b1;
        op               <= w.op;
        dest_addr        <= w.dest;
        subnet_mask      <= w.mask;
        next_hop         <= w.hop;
        out_port_in      <= w.port;
        port_present_in  <= w.present;
        metric           <= w.metric;
        proto_ospf       <= w.proto;
        in_routing_phase <= w.phase;
        do
            @(posedge clk);
        while (busy);
        sb.note_word(w);
    endtask

    task automatic idle_gap(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop start and wait for every outstanding reply, then a few spare cycles.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only call with the block idle.
    task automatic write_limit(logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_limit(value);
    endtask

    // Random word of the given operation; every field carries random content.
    function automatic cmd_word_t random_word(op_t kind);
        cmd_word_t w;
        w.op      = kind;
        w.dest    = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                : $urandom;
        w.mask    = $urandom;
        w.hop     = $urandom;
        w.port    = 8'($urandom_range(0, 255));
        w.present = 1'($urandom_range(0, 1));
        // Narrow metrics half the time, so equal and better routes turn up often.
        w.metric  = $urandom_range(0, 1) ? 16'($urandom_range(0, 15))
                                         : 16'($urandom_range(0, 65535));
        w.proto   = 1'($urandom_range(0, 1));
        w.phase   = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic cmd_word_t update_word(logic [31:0] dest, logic [7:0] port,
                                              logic present, logic [15:0] cost);
        cmd_word_t w;
        w         = random_word(OP_UPDATE);
        w.dest    = dest;
        w.port    = port;
        w.present = present;
        w.metric  = cost;
        return w;
    endfunction

    function automatic cmd_word_t lookup_word(logic [31:0] dest);
        cmd_word_t w;
        w      = random_word(OP_LOOKUP);
        w.dest = dest;
        return w;
    endfunction

    function automatic cmd_word_t tick_word(logic phase);
        cmd_word_t w;
        w       = random_word(OP_TICK);
        w.phase = phase;
        return w;
    endfunction

    task automatic maybe_idle(bit idling);
        if (idling && $urandom_range(0, 4) == 0)
            idle_gap($urandom_range(1, 8));
    endtask

    // Send one random stretch: mostly a start followed by a run of up to lim + 4
    // routing ticks (at most 24), with the odd update or lookup mixed in;
    // the rest is loose noise words.
    task automatic random_block(int lim, int words, bit idling);
        int sent;
        int ticks;
        int pick;
        sent = 0;
        while (sent < words)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                send_word(random_word(OP_START));
                maybe_idle(idling);
                sent++;
                ticks = $urandom_range(0, (lim + 4 > 24) ? 24 : lim + 4);
                for (int i = 0; i < ticks; i++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        send_word(random_word(OP_UPDATE));
                    else if (pick == 1)
                        send_word(random_word(OP_LOOKUP));
                    else
                        send_word(tick_word(1'b1));
                    maybe_idle(idling);
                    sent++;
                end
                if ($urandom_range(0, 9) < 7)
                begin
                    send_word(tick_word(1'b0));
                    maybe_idle(idling);
                    sent++;
                end
            end
            else
            begin
                send_word(random_word(op_t'($urandom_range(0, 3))));
                maybe_idle(idling);
                sent++;
            end
        end
    endtask

    initial
    begin
        int block_limits [6];

        block_limits = '{1, 0, 5, 2, 9, 16};
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;

        // Hold reset low from time zero, then release it on a clock edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Zero limit first, so convergence is visible in a handful of ticks.
        write_limit(16'd0);

        // Directed words: timer before and after start, repeated start,
        // extreme fields, a route with no port, equal/worse/better metrics,
        // a lookup miss and a tick outside the routing phase.
        send_word(tick_word(1'b1));
        send_word(random_word(OP_START));
        send_word(tick_word(1'b1));
        send_word(tick_word(1'b1));
        send_word(random_word(OP_START));
        send_word(tick_word(1'b1));
        send_word(tick_word(1'b0));
        send_word(update_word(32'h0000_0000, 8'h00, 1'b1, 16'hFFFF));
        send_word(update_word(32'hFFFF_FFFF, 8'hFF, 1'b1, 16'h0000));
        send_word(update_word(32'h0A00_0001, 8'hA5, 1'b0, 16'd100));
        send_word(lookup_word(32'h0000_0000));
        send_word(lookup_word(32'hFFFF_FFFF));
        send_word(lookup_word(32'h0A00_0001));
        send_word(lookup_word(32'h1234_5678));
        send_word(update_word(32'h0A00_0001, 8'h11, 1'b1, 16'd100));
        send_word(update_word(32'h0A00_0001, 8'h22, 1'b1, 16'd101));
        send_word(update_word(32'h0A00_0001, 8'h07, 1'b1, 16'd99));
        send_word(lookup_word(32'h0A00_0001));
        send_word(update_word(32'h0000_0000, 8'h5A, 1'b1, 16'h0000));
        send_word(random_word(OP_START));
        send_word(tick_word(1'b1));
        send_word(tick_word(1'b1));
        send_word(tick_word(1'b0));

        // Random stretches, each under its own limit; the table fills along
        // the way, so later inserts turn into drops. The fourth stretch and
        // the last run without idle gaps.
        for (int b = 0; b < 6; b++)
        begin
            drain();
            write_limit(16'(block_limits[b]));
            random_block(block_limits[b], BLOCK_WORDS, (b != 3) && (b != 5));
        end

        // Top limit: a short run of routing ticks after an update must not converge.
        drain();
        write_limit(IDLE_TICKS_MAX);
        send_word(tick_word(1'b0));
        send_word(random_word(OP_START));
        send_word(random_word(OP_UPDATE));
        for (int i = 0; i < 8; i++)
            send_word(tick_word(1'b1));
        send_word(tick_word(1'b0));

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/rtct_pkg.sv
src/rtct_ram.sv
src/rtct_datapath.sv
src/rtct_ctrl.sv
src/routing_table_with_convergence_timer_core.sv
verif/tb_routing_table_with_convergence_timer_core.sv
